FILE: hw/rtl/urta_pkg.sv
// Shared types, codes and character helpers for the radix-to-ASCII converter.
package urta_pkg;

    // Width of the value port.
    localparam int VALUE_W = 32;

    // Conversion commands.
    localparam logic [1:0] CMD_OCT       = 2'd0;
    localparam logic [1:0] CMD_DEC       = 2'd1;
    localparam logic [1:0] CMD_HEX_LOWER = 2'd2;
    localparam logic [1:0] CMD_HEX_UPPER = 2'd3;

    // ASCII codes used for prefixes and digits.
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_X_LOWER = 8'h78;
    localparam logic [7:0] CHAR_X_UPPER = 8'h58;
    localparam logic [7:0] CHAR_A_LOWER = 8'h61;
    localparam logic [7:0] CHAR_A_UPPER = 8'h41;

    // Reciprocal of ten scaled by 2^35; exact quotient for any 32-bit value.
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic extract;
        logic emit;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic quot_zero;
        logic out_free;
        logic emit_last;
    } t_dp_status;

    // Maps one digit to its ASCII code.
    function automatic logic [7:0] digit_char(input logic [3:0] digit, input logic upper);
        logic [7:0] base;
        begin
            if (digit < 4'd10) begin
                digit_char = CHAR_ZERO + {4'd0, digit};
            end else begin
                base = upper ? CHAR_A_UPPER : CHAR_A_LOWER;
                digit_char = base + {4'd0, digit} - 8'd10;
            end
        end
    endfunction

endpackage

FILE: hw/rtl/urta_controller.sv
// Sequencing state machine of the radix-to-ASCII converter.
module urta_controller (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  urta_pkg::t_dp_status  i_status,
    output urta_pkg::t_ctl_cmd    o_cmd
);
    import urta_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_EXTRACT = 2'd1;
    localparam logic [1:0] ST_EMIT    = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_ready = (r_state == ST_IDLE);

    // Commands and next state.
    always_comb begin
        n_state       = r_state;
        o_cmd.load    = 1'b0;
        o_cmd.extract = 1'b0;
        o_cmd.emit    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXTRACT;
                end
            end
            ST_EXTRACT: begin
                o_cmd.extract = 1'b1;
                if (i_status.quot_zero) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hw/rtl/urta_datapath.sv
// Digit extraction, digit stack and output register of the radix-to-ASCII converter.
module urta_datapath #(
    parameter int VAL_W = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  urta_pkg::t_ctl_cmd            i_cmd,
    input  logic [urta_pkg::VALUE_W-1:0]  i_value,
    input  logic [1:0]                    i_command,
    input  logic                          i_alternate,
    input  logic                          i_out_ready,
    output urta_pkg::t_dp_status          o_status,
    output logic                          o_out_valid,
    output logic [7:0]                    o_character,
    output logic                          o_last
);
    import urta_pkg::*;

    localparam int DIG_MAX = (VAL_W + 2) / 3;
    localparam int CW      = $clog2(DIG_MAX + 1);
    localparam int IW      = $clog2(DIG_MAX);
    localparam int PW      = VAL_W + 32;

    logic [VAL_W-1:0] r_val;
    logic [PW-1:0]    r_prod;
    logic [1:0]       r_mode;
    logic [1:0]       r_pfx;
    logic [CW-1:0]    r_cnt;
    logic [3:0]       r_buf [DIG_MAX];
    logic [7:0]       r_char;
    logic             r_last;
    logic             r_out_valid;

    logic [VAL_W-1:0] val_in;
    logic             val_nz;
    logic [1:0]       pfx_in;
    logic [VAL_W-1:0] q_dec;
    logic [VAL_W-1:0] q_dec10;
    logic [VAL_W-1:0] rem_dec;
    logic [VAL_W-1:0] next_val;
    logic [3:0]       digit;
    logic [CW-1:0]    cnt_m1;
    logic             is_hex;
    logic             is_upper;
    logic [7:0]       emit_char;

    // Input value restricted to the configured width.
    assign val_in = i_value[VAL_W-1:0];
    assign val_nz = |val_in;

    // Prefix length in alternate form: one for octal, two for hex, only on a nonzero value.
    always_comb begin
        pfx_in = 2'd0;
        if (val_nz && i_alternate) begin
            if (i_command == CMD_OCT) begin
                pfx_in = 2'd1;
            end else if (i_command == CMD_HEX_LOWER || i_command == CMD_HEX_UPPER) begin
                pfx_in = 2'd2;
            end
        end
    end

    // Decimal quotient from the registered reciprocal product and its remainder.
    assign q_dec   = {3'b000, r_prod[PW-1:RECIP_SHIFT]};
    assign q_dec10 = (q_dec << 3) + (q_dec << 1);
    assign rem_dec = r_val - q_dec10;

    // Low digit and remaining value for the current radix.
    always_comb begin
        unique case (r_mode)
            CMD_OCT: begin
                digit    = {1'b0, r_val[2:0]};
                next_val = r_val >> 3;
            end
            CMD_DEC: begin
                digit    = rem_dec[3:0];
                next_val = q_dec;
            end
            default: begin
                digit    = r_val[3:0];
                next_val = r_val >> 4;
            end
        endcase
    end

    // Character selection for emission: prefix first, then digits from the top.
    assign is_hex   = (r_mode == CMD_HEX_LOWER) || (r_mode == CMD_HEX_UPPER);
    assign is_upper = (r_mode == CMD_HEX_UPPER);
    assign cnt_m1   = r_cnt - 1'b1;

    always_comb begin
        if (r_pfx != 2'd0) begin
            if (r_pfx == 2'd1 && is_hex) begin
                emit_char = is_upper ? CHAR_X_UPPER : CHAR_X_LOWER;
            end else begin
                emit_char = CHAR_ZERO;
            end
        end else begin
            emit_char = digit_char(r_buf[cnt_m1[IW-1:0]], is_upper);
        end
    end

    // Status to the controller.
    assign o_status.quot_zero = (next_val == '0);
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.emit_last = (r_pfx == 2'd0) && (r_cnt == CW'(1));

    // Value, product and digit stack.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val  <= val_in;
            r_prod <= val_in * RECIP_TEN;
            r_mode <= i_command;
        end else if (i_cmd.extract) begin
            r_val  <= next_val;
            r_prod <= q_dec * RECIP_TEN;
            r_buf[r_cnt[IW-1:0]] <= digit;
        end
    end

    // Prefix and digit counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pfx <= 2'd0;
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_pfx <= pfx_in;
            r_cnt <= '0;
        end else if (i_cmd.extract) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.emit) begin
            if (r_pfx != 2'd0) begin
                r_pfx <= r_pfx - 2'd1;
            end else begin
                r_cnt <= cnt_m1;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_char <= emit_char;
            r_last <= (r_pfx == 2'd0) && (r_cnt == CW'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule

FILE: hw/rtl/unsigned_radix_to_ascii.sv
// Unsigned radix-to-ASCII converter, top level.
// Each request converts an unsigned value to octal, decimal or hex ASCII digits, most
// significant first, one character per output transfer, with last set on the final one;
// zero gives a single '0', and in alternate form a nonzero octal value gets a '0' prefix
// and a nonzero hex value '0x' or '0X'. A request is accepted in the idle state, then the
// digit extraction loop takes one digit per cycle (a shift for octal and hex, a reciprocal
// multiply by ten for decimal), then one prefix or digit character goes out per cycle
// while the output side is ready. A new request is taken once the last character has gone
// into the output register.
module unsigned_radix_to_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [urta_pkg::VALUE_W-1:0]  i_value,
    input  logic [1:0]                    i_command,
    input  logic                          i_alternate,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [7:0]                    o_character,
    output logic                          o_last
);
    import urta_pkg::*;

    localparam int VAL_W = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

    t_ctl_cmd   ctl_cmd;
    t_dp_status dp_status;

    // Sequencer.
    urta_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (dp_status),
        .o_cmd    (ctl_cmd)
    );

    // Datapath.
    urta_datapath #(
        .VAL_W (VAL_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctl_cmd),
        .i_value     (i_value),
        .i_command   (i_command),
        .i_alternate (i_alternate),
        .i_out_ready (i_ready),
        .o_status    (dp_status),
        .o_out_valid (o_valid),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

FILE: dv/unsigned_radix_to_ascii_tb.sv
// Self-checking testbench for the unsigned radix-to-ASCII converter.
`timescale 1ns / 100ps

module unsigned_radix_to_ascii_tb;

    import urta_pkg::*;

    localparam int N_DIRECTED     = 23;
    localparam int N_RANDOM       = 357;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 30;
    localparam int MAX_REPORTED   = 10;
    localparam logic [95:0] PREDICT = '0;

    // One emitted character as the block should produce it.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_ascii_out;

    // One directed request; a nonzero text is the literal expected output.
    typedef struct {
        logic [31:0] value;
        logic [1:0]  cmd;
        logic        alt;
        logic [95:0] text;
    } t_conv_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [VALUE_W-1:0]   i_value;
    logic [1:0]           i_command;
    logic                 i_alternate;
    logic                 o_valid;
    logic                 i_ready;
    logic [7:0]           o_character;
    logic                 o_last;

    t_ascii_out  expected_chars[$];
    t_conv_row   directed_rows[N_DIRECTED];
    int          error_count    = 0;
    int          chars_checked  = 0;
    int          requests_sent  = 0;
    int          input_stalls   = 0;
    int          hold_request   = 0;
    int          long_holds     = 0;
    int          cmd_count[4]   = '{0, 0, 0, 0};
    bit          calm           = 1'b0;

    unsigned_radix_to_ascii DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .i_command   (i_command),
        .i_alternate (i_alternate),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

    // Free-running clock, 20 ns period.
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Safety net against a hung handshake.
    initial begin
        #50_000_000;
        $display("unsigned_radix_to_ascii_tb NOT OK");
        $finish;
    end

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTED) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int idle_cycles();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Queues the characters a conversion must produce: optional radix prefix,
    // then the digits most significant first, last set on the final one.
    function automatic void predict_chars(input logic [31:0] value, input logic [1:0] cmd,
                                          input logic alt);
        logic [7:0]  digits[$];
        logic [7:0]  seq[$];
        logic [31:0] rest;
        logic [31:0] radix;
        logic [7:0]  d;
        bit          upper;
        upper = (cmd == CMD_HEX_UPPER);
        case (cmd)
            CMD_OCT: radix = 32'd8;
            CMD_DEC: radix = 32'd10;
            default: radix = 32'd16;
        endcase
        rest = value;
        if (rest == '0) begin
            // Zero is a lone '0' in every mode, never prefixed.
            seq.push_back(8'h30);
        end else begin
            while (rest != '0) begin
                d = 8'(rest % radix);
                if (d < 8'd10) begin
                    digits.push_front(8'h30 + d);
                end else begin
                    digits.push_front((upper ? 8'h41 : 8'h61) + d - 8'd10);
                end
                rest = rest / radix;
            end
            if (alt && cmd == CMD_OCT) begin
                seq.push_back(8'h30);
            end else if (alt && (cmd == CMD_HEX_LOWER || cmd == CMD_HEX_UPPER)) begin
                seq.push_back(8'h30);
                seq.push_back(upper ? 8'h58 : 8'h78);
            end
            foreach (digits[k]) begin
                seq.push_back(digits[k]);
            end
        end
        foreach (seq[k]) begin
            expected_chars.push_back(t_ascii_out'{seq[k], k == seq.size() - 1});
        end
    endfunction

    // Random value biased toward digit-count boundaries and extremes.
    function automatic logic [31:0] pick_value();
        logic [31:0] p;
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 17);
            1: return $urandom;
            2: return (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
            3: begin
                p = 32'd1;
                repeat ($urandom_range(0, 9)) p = p * 32'd10;
                return p - $urandom_range(0, 1);
            end
            4: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    // Presents one request and returns at the edge where it is accepted.
    task automatic offer_request(input logic [31:0] value, input logic [1:0] cmd,
                                 input logic alt);
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_value     <= value;
        i_command   <= cmd;
        i_alternate <= alt;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        requests_sent++;
        cmd_count[cmd]++;
    endtask

    // Sender idles after an accepted request, if at all.
    task automatic sender_gap();
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    initial begin : result_sink
        int stall;
        int run;
        i_ready = 1'b0;
        forever begin
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
                repeat (stall) begin
                    @(negedge i_clk);
                    i_ready <= 1'b0;
                end
                long_holds++;
            end else begin
                stall = idle_cycles();
                run   = $urandom_range(1, 12);
                repeat (stall) begin
                    @(negedge i_clk);
                    i_ready <= 1'b0;
                end
                repeat (run) begin
                    @(negedge i_clk);
                    i_ready <= 1'b1;
                end
            end
        end
    end

    // Checks every accepted character against the oldest expectation.
    always @(posedge i_clk) begin
        t_ascii_out want;
        if (i_rst_n && i_valid && !o_ready) begin
            input_stalls++;
        end
        if (i_rst_n && o_valid && i_ready) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
                flag_error($sformatf("character: expected none, got 0x%02h last=%0b",
                                     o_character, o_last));
            end else begin
                want = expected_chars.pop_front();
                if (o_character !== want.ch) begin
                    flag_error($sformatf("character: expected 0x%02h, got 0x%02h",
                                         want.ch, o_character));
                end
                if (o_last !== want.last) begin
                    flag_error($sformatf("last: expected %0b, got %0b", want.last, o_last));
                end
            end
        end
    end

    // Reset, directed table, random requests, then drain and verdict.
    initial begin : stimulus
        int          n;
        logic [31:0] v;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_value     = '0;
        i_command   = CMD_OCT;
        i_alternate = 1'b0;

        directed_rows = '{
            '{32'd0,           CMD_OCT,       1'b1, "0"},
            '{32'd0,           CMD_DEC,       1'b0, "0"},
            '{32'd0,           CMD_HEX_LOWER, 1'b1, "0"},
            '{32'd0,           CMD_HEX_UPPER, 1'b1, "0"},
            '{32'hFFFF_FFFF,   CMD_OCT,       1'b1, "037777777777"},
            '{32'hFFFF_FFFF,   CMD_OCT,       1'b0, "37777777777"},
            '{32'hFFFF_FFFF,   CMD_DEC,       1'b1, "4294967295"},
            '{32'hFFFF_FFFF,   CMD_HEX_LOWER, 1'b1, "0xffffffff"},
            '{32'hFFFF_FFFF,   CMD_HEX_UPPER, 1'b1, "0XFFFFFFFF"},
            '{32'hFFFF_FFFF,   CMD_HEX_UPPER, 1'b0, "FFFFFFFF"},
            '{32'd1,           CMD_OCT,       1'b1, "01"},
            '{32'd1,           CMD_HEX_LOWER, 1'b1, "0x1"},
            '{32'd1,           CMD_DEC,       1'b1, "1"},
            '{32'd10,          CMD_DEC,       1'b0, PREDICT},
            '{32'd9,           CMD_DEC,       1'b1, PREDICT},
            '{32'd100,         CMD_DEC,       1'b0, PREDICT},
            '{32'h89AB_CDEF,   CMD_HEX_LOWER, 1'b0, PREDICT},
            '{32'hDEAD_BEEF,   CMD_HEX_UPPER, 1'b1, PREDICT},
            '{32'h8000_0000,   CMD_OCT,       1'b0, PREDICT},
            '{32'd999999999,   CMD_DEC,       1'b0, PREDICT},
            '{32'd1000000000,  CMD_DEC,       1'b1, PREDICT},
            '{32'h1234_5678,   CMD_OCT,       1'b1, PREDICT},
            '{32'hA,           CMD_HEX_UPPER, 1'b1, PREDICT}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests; literal rows carry their text right-aligned.
        foreach (directed_rows[r]) begin
            offer_request(directed_rows[r].value, directed_rows[r].cmd, directed_rows[r].alt);
            if (directed_rows[r].text == PREDICT) begin
                predict_chars(directed_rows[r].value, directed_rows[r].cmd,
                              directed_rows[r].alt);
            end else begin
                n = 0;
                for (int k = 0; k < 12; k++) begin
                    if (directed_rows[r].text[k*8 +: 8] != 8'h00) n = k + 1;
                end
                for (int k = n - 1; k >= 0; k--) begin
                    expected_chars.push_back(
                        t_ascii_out'{directed_rows[r].text[k*8 +: 8], k == 0});
                end
            end
            sender_gap();
        end

        // Random requests, with one long output hold-off and a gap-free stretch.
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 120) hold_request = LONG_HOLD;
            calm = (i >= 250 && i < 300);
            v = pick_value();
            offer_request(v, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            predict_chars(v, i_command, i_alternate);
            sender_gap();
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d requests (oct %0d, dec %0d, hex %0d, HEX %0d), %0d characters",
                 requests_sent, cmd_count[CMD_OCT], cmd_count[CMD_DEC],
                 cmd_count[CMD_HEX_LOWER], cmd_count[CMD_HEX_UPPER], chars_checked);
        $display("Input back-pressure seen on %0d cycles, %0d long output hold-off(s), %0d errors",
                 input_stalls, long_holds, error_count);
        if (error_count == 0 && expected_chars.size() == 0) begin
            $display("unsigned_radix_to_ascii_tb OK");
        end else begin
            $display("unsigned_radix_to_ascii_tb NOT OK");
        end
        $finish;
    end

endmodule
